[hw/rtl/tli_pkg.sv]
package tli_pkg;

    localparam int DEPTH      = 32;
    localparam int VAL_W      = 16;
    localparam int KEY_W      = 16;
    localparam int IDX_W      = 5;
    localparam int CFG_W      = 6;
    localparam int PROD_W     = VAL_W + KEY_W;
    localparam int SRCH_CNT_W = $clog2(DEPTH);
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    // command carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // range flag codes
    localparam logic [1:0] FLAG_INSIDE = 2'd0;
    localparam logic [1:0] FLAG_BELOW  = 2'd1;
    localparam logic [1:0] FLAG_ABOVE  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val_a;
        logic [VAL_W-1:0] val_b;
    } row_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic [KEY_W-1:0] q;
        logic             found;
        logic             first;
        row_t             lo;
        row_t             hi;
    } token_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

[hw/rtl/tli_cell.sv]
module tli_cell import tli_pkg::*; (
    input  logic   aclk,
    input  logic   wr_en,
    input  row_t   wr_row,
    input  logic   active,
    input  logic   is_first,
    input  token_t tok_in,
    output token_t tok_out
);

    row_t   row_reg;
    token_t tok_reg;
    token_t tok_next;

    // one table row held in this cell
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_reg <= wr_row;
        end
    end

    // first row at or above the query stops the search, earlier rows become the lower row
    always_comb begin
        tok_next = tok_in;
        if (active && !tok_in.found) begin
            if (row_reg.key >= tok_in.q) begin
                tok_next.found = 1'b1;
                tok_next.first = is_first;
                tok_next.hi    = row_reg;
            end else begin
                tok_next.lo = row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/tli_div.sv]
module tli_div import tli_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [KEY_W-1:0]  divisor,
    output logic              done,
    output logic [VAL_W-1:0]  quot,
    output logic              rem_nz
);

    logic [PROD_W-1:0]    dvd_reg, dvd_next;
    logic [KEY_W-1:0]     rem_reg, rem_next;
    logic [KEY_W-1:0]     d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [KEY_W:0]       rem_sh;
    logic [KEY_W-1:0]     rem_sub;
    logic                 ge;

    // one restoring step per cycle
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[PROD_W-1]};
        rem_sub  = rem_sh[KEY_W-1:0] - d_reg;
        ge       = rem_sh >= {1'b0, d_reg};
        rem_next = ge ? rem_sub : rem_sh[KEY_W-1:0];
        dvd_next = {dvd_reg[PROD_W-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(PROD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done   = done_reg;
    assign quot   = dvd_reg[VAL_W-1:0];
    assign rem_nz = |rem_reg;

endmodule

[hw/rtl/table_linear_interpolator_core.sv]
// an interpolated query passes the DEPTH-cell token walk, the end-of-search decode and a
// 32-step bit-serial divide before its item is registered at the output; a query that needs no
// divide skips the divide
// one query at a time: no new input is accepted until the query's item is loaded into the output
// register; a row write returns no item; a waiting result stalls only the next query
// reset: aresetn synchronous active low, clears control and sets entries_in_use to 1
module table_linear_interpolator_core import tli_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,   // entries_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,       // row_index, row_distance, row_first_value,
                                       // row_second_value, query_distance, zero pad
    input  logic        s_tuser,       // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // first_setting, second_setting
    output logic [1:0]  m_tuser        // range_flag
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]      entries_reg;
    logic [CFG_W-1:0]      n_eff;
    logic [SRCH_CNT_W-1:0] scnt_reg;
    logic [KEY_W-1:0]      q_reg;
    logic                  s_acc;
    logic                  wr_acc;
    row_t                  wr_row;
    logic [IDX_W-1:0]      wr_idx;
    token_t                tok [DEPTH+1];
    logic [DEPTH-1:0]      active;

    logic                  interp_reg;
    logic                  down_a_reg, down_b_reg;
    logic [VAL_W-1:0]      base_a_reg, base_b_reg;
    logic [VAL_W-1:0]      diff_a_reg, diff_b_reg;
    logic [KEY_W-1:0]      t_reg, d_reg;
    logic [VAL_W-1:0]      res_a_reg, res_b_reg;
    logic [1:0]            flag_reg;
    logic                  div_start;
    logic                  div_done_a, div_done_b;
    logic [VAL_W-1:0]      quot_a, quot_b;
    logic                  rnz_a, rnz_b;
    logic [VAL_W-1:0]      fin_a, fin_b;
    logic [PROD_W-1:0]     prod_a, prod_b;
    logic                  out_load;

    logic                  m_tvalid_reg;
    logic [VAL_W-1:0]      m_a_reg, m_b_reg;
    logic [1:0]            m_flag_reg;

    assign s_acc  = s_tvalid && s_tready;
    assign wr_acc = s_acc && (s_tuser == CMD_WRITE);
    assign wr_idx = s_tdata[4:0];
    assign wr_row = '{key: s_tdata[20:5], val_a: s_tdata[36:21], val_b: s_tdata[52:37]};

    // row count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            entries_reg <= cfg_wr_data;
        end
    end

    // saturate row count to 1 .. DEPTH
    always_comb begin
        if (entries_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (entries_reg > CFG_W'(DEPTH)) begin
            n_eff = CFG_W'(DEPTH);
        end else begin
            n_eff = entries_reg;
        end
    end

    // injected token
    assign tok[0] = '{q: q_reg, default: '0};

    // chain of table cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign active[i] = CFG_W'(i) < n_eff;
        tli_cell u_cell (
            .aclk     (aclk),
            .wr_en    (wr_acc && (wr_idx == IDX_W'(i))),
            .wr_row   (wr_row),
            .active   (active[i]),
            .is_first (i == 0),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == CMD_QUERY)) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (scnt_reg == SRCH_CNT_W'(DEPTH - 1)) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = (tok[DEPTH].found && !tok[DEPTH].first) ? ST_MUL : ST_FINISH;
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_done_a && div_done_b) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_MUL:    div_start = 1'b1;
            ST_FINISH: out_load  = !m_tvalid_reg || m_tready;
            default:   s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SEARCH) begin
                scnt_reg <= scnt_reg + 1'b1;
            end else begin
                scnt_reg <= '0;
            end
        end
    end

    // query capture and end-of-search decode
    always_ff @(posedge aclk) begin
        if (s_acc && (s_tuser == CMD_QUERY)) begin
            q_reg <= s_tdata[68:53];
        end
        if (state_reg == ST_LOAD) begin
            interp_reg <= tok[DEPTH].found && !tok[DEPTH].first;
            if (!tok[DEPTH].found) begin
                res_a_reg <= tok[DEPTH].lo.val_a;
                res_b_reg <= tok[DEPTH].lo.val_b;
                flag_reg  <= FLAG_ABOVE;
            end else if (tok[DEPTH].first) begin
                res_a_reg <= tok[DEPTH].hi.val_a;
                res_b_reg <= tok[DEPTH].hi.val_b;
                flag_reg  <= (q_reg < tok[DEPTH].hi.key) ? FLAG_BELOW : FLAG_INSIDE;
            end else begin
                flag_reg  <= FLAG_INSIDE;
            end
            base_a_reg <= tok[DEPTH].lo.val_a;
            base_b_reg <= tok[DEPTH].lo.val_b;
            down_a_reg <= tok[DEPTH].hi.val_a < tok[DEPTH].lo.val_a;
            down_b_reg <= tok[DEPTH].hi.val_b < tok[DEPTH].lo.val_b;
            diff_a_reg <= (tok[DEPTH].hi.val_a < tok[DEPTH].lo.val_a)
                        ? tok[DEPTH].lo.val_a - tok[DEPTH].hi.val_a
                        : tok[DEPTH].hi.val_a - tok[DEPTH].lo.val_a;
            diff_b_reg <= (tok[DEPTH].hi.val_b < tok[DEPTH].lo.val_b)
                        ? tok[DEPTH].lo.val_b - tok[DEPTH].hi.val_b
                        : tok[DEPTH].hi.val_b - tok[DEPTH].lo.val_b;
            t_reg      <= q_reg - tok[DEPTH].lo.key;
            d_reg      <= tok[DEPTH].hi.key - tok[DEPTH].lo.key;
        end
    end

    // full-width products of difference and offset
    assign prod_a = PROD_W'(diff_a_reg) * PROD_W'(t_reg);
    assign prod_b = PROD_W'(diff_b_reg) * PROD_W'(t_reg);

    // one divider lane per setting, product registered inside the divider
    tli_div u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_a),
        .divisor  (d_reg),
        .done     (div_done_a),
        .quot     (quot_a),
        .rem_nz   (rnz_a)
    );

    tli_div u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_b),
        .divisor  (d_reg),
        .done     (div_done_b),
        .quot     (quot_b),
        .rem_nz   (rnz_b)
    );

    // floor: add quotient going up, subtract ceiling going down
    always_comb begin
        fin_a = down_a_reg ? base_a_reg - quot_a - VAL_W'(rnz_a) : base_a_reg + quot_a;
        fin_b = down_b_reg ? base_b_reg - quot_b - VAL_W'(rnz_b) : base_b_reg + quot_b;
        if (!interp_reg) begin
            fin_a = res_a_reg;
            fin_b = res_b_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_a_reg    <= fin_a;
            m_b_reg    <= fin_b;
            m_flag_reg <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_b_reg, m_a_reg};
    assign m_tuser  = m_flag_reg;

endmodule

[hw/rtl/tli_checker.sv]
module tli_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser
);

    // no item right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // flag code three is never produced
    a_flag_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("bad range flag");

    // a query occupies the block
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("input taken during a query");

    // a row write creates no item
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
        else $error("result after a row write");

    // a stalled result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind table_linear_interpolator_core tli_checker u_tli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);
